/* sv/gradient_weighted_binarizer_assert.svh */
// Assertion macros for the gradient weighted binarizer.
`ifndef GRADIENT_WEIGHTED_BINARIZER_ASSERT_SVH
`define GRADIENT_WEIGHTED_BINARIZER_ASSERT_SVH
// same-cycle implication
`define GWB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gwb assertion failed");
// next-cycle implication
`define GWB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gwb assertion failed");
`endif

/* sv/gwb_pkg.sv */
// Shared types and constants of the gradient weighted binarizer.
package gwb_pkg;
	localparam int PIX_W          = 8;
	localparam int CFG_W          = 11;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic ACT_MEASURE  = 1'b0;
	localparam logic ACT_BINARIZE = 1'b1;
	localparam logic KIND_THRESH  = 1'b0;
	localparam logic KIND_PIXEL   = 1'b1;
	localparam logic REG_WIDTH    = 1'b0;
	localparam logic REG_HEIGHT   = 1'b1;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] gray;
	} item_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] quo;
	} div_rsp_t;
endpackage

/* sv/gwb_front.sv */
// Input request queue: accepts pixels and hands them to the back end in order.
module gwb_front import gwb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t in_item,
	output logic  full,
	output logic  head_v,
	output item_t head,
	input  logic  head_pop
);
	item_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full     = (cnt_q == 2'd2);
	assign head_v   = (cnt_q != 2'd0);
	assign head     = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = head_pop && head_v;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

/* sv/gwb_div.sv */
// Restoring divider, one quotient bit per cycle, result clamped to 8 bits.
module gwb_div import gwb_pkg::*; #(
	parameter int WW = 37,
	parameter int GW = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [WW-1:0] dividend,
	input  logic [GW-1:0] divisor,
	output div_rsp_t      rsp
);
	localparam int CW = $clog2(WW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [WW-1:0] dvd_q;
	logic [GW-1:0] dvs_q;
	logic [GW-1:0] rem_q;
	logic [GW:0]   rem_sh;
	logic          ge;
	logic          last;

	assign rem_sh = {rem_q, dvd_q[WW-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});
	assign last   = busy_q && (cnt_q == CW'(WW - 1));

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WW-2:0], ge};
			rem_q <= ge ? GW'(rem_sh - {1'b0, dvs_q}) : rem_sh[GW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) busy_q <= 1'b0;
			end
		end
	end

	assign rsp = '{done: done_q,
		quo: (|dvd_q[WW-1:PIX_W]) ? {PIX_W{1'b1}} : dvd_q[PIX_W-1:0]};
endmodule

/* sv/gwb_back.sv */
// Back end: line buffers, gradient sums, threshold sequencing and result register.
module gwb_back import gwb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [$clog2(MAX_WIDTH):0]    w,
	input  logic [$clog2(MAX_HEIGHT):0]   h,
	input  logic                          head_v,
	input  item_t                         head,
	output logic                          head_pop,
	output logic                          out_v,
	input  logic                          out_pop,
	output logic                          out_kind,
	output logic                          out_bit,
	output logic [PIX_W-1:0]              out_thr,
	output logic                          out_flat
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int GW = XW + YW + PIX_W;
	localparam int WW = XW + YW + 2 * PIX_W + 1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_RD     = 6'b000010,
		S_ACC    = 6'b000100,
		S_DIV_ST = 6'b001000,
		S_DIV_WT = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q;

	logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] nx_rd_q, nx1_rd_q, ox_rd_q;

	logic [XW-1:0]    x_q;
	logic [YW-1:0]    y_q;
	logic [PIX_W-1:0] pix_q, nw0_q, nw1_q, nw2_q;
	logic [WW-1:0]    wsum_q;
	logic [GW-1:0]    gsum_q;
	logic [PIX_W-1:0] thr_q;
	logic             flat_q;

	logic [PIX_W-1:0] c0_s1, g0_s1, c1_s1, g1_s1, c2_s1, g2_s1;
	logic             done_s1;

	logic             out_free, meas_take, bin_take, out_wr_thr;
	logic             oob;
	logic [XW-1:0]    xs;
	logic [YW-1:0]    ys;
	div_rsp_t         drsp;
	logic             div_start;

	// RD stage neighborhood
	logic             en0, en1, en2, lastrow, xlast, right_ok;
	logic [PIX_W-1:0] c0, up0, left0, right0, up1, left1, up2, left2;
	logic [PIX_W-1:0] g0, g1, g2;
	logic [2*PIX_W-1:0] p0, p1, p2;

	function automatic logic [PIX_W-1:0] adiff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [PIX_W-1:0] gmax(input logic [PIX_W-1:0] gx,
		input logic [PIX_W-1:0] gy);
		return (gx > gy) ? gx : gy;
	endfunction

	assign out_free  = !out_v || out_pop;
	assign meas_take = (state_q == S_IDLE) && head_v && (head.action == ACT_MEASURE);
	assign bin_take  = (state_q == S_IDLE) && head_v && (head.action == ACT_BINARIZE)
		&& out_free;
	assign head_pop  = meas_take || bin_take;
	assign out_wr_thr = (state_q == S_EMIT) && out_free;

	assign oob = ({1'b0, x_q} >= w) || ({1'b0, y_q} >= h);
	assign xs  = oob ? '0 : x_q;
	assign ys  = oob ? '0 : y_q;

	always_ff @(posedge clk) begin
		if (meas_take) begin
			nx_rd_q  <= newer_mem[xs];
			nx1_rd_q <= newer_mem[xs + XW'(1)];
			ox_rd_q  <= older_mem[xs];
		end
		if (state_q == S_RD) begin
			newer_mem[x_q] <= pix_q;
			if (en0) older_mem[x_q] <= c0;
		end
	end

	always_comb begin
		en0      = (y_q != '0);
		lastrow  = ({1'b0, y_q} == h - (YW+1)'(1));
		xlast    = ({1'b0, x_q} == w - (XW+1)'(1));
		right_ok = (({1'b0, x_q} + (XW+1)'(1)) < w);
		en1      = lastrow && (x_q != '0);
		en2      = lastrow && xlast;
		c0       = nx_rd_q;
		up0      = (y_q == YW'(1)) ? c0 : ox_rd_q;
		left0    = (x_q != '0) ? nw0_q : c0;
		right0   = right_ok ? nx1_rd_q : c0;
		g0       = en0 ? gmax(adiff(right0, left0), adiff(pix_q, up0)) : '0;
		up1      = (y_q == '0) ? nw1_q : nw0_q;
		left1    = (x_q > XW'(1)) ? nw2_q : nw1_q;
		g1       = en1 ? gmax(adiff(pix_q, left1), adiff(nw1_q, up1)) : '0;
		up2      = (y_q == '0) ? pix_q : c0;
		left2    = (x_q != '0) ? nw1_q : pix_q;
		g2       = en2 ? gmax(adiff(pix_q, left2), adiff(pix_q, up2)) : '0;
	end

	assign p0 = (2*PIX_W)'(c0_s1) * (2*PIX_W)'(g0_s1);
	assign p1 = (2*PIX_W)'(c1_s1) * (2*PIX_W)'(g1_s1);
	assign p2 = (2*PIX_W)'(c2_s1) * (2*PIX_W)'(g2_s1);

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			c0_s1 <= en0 ? c0 : '0;
			g0_s1 <= g0;
			c1_s1 <= nw1_q;
			g1_s1 <= g1;
			c2_s1 <= pix_q;
			g2_s1 <= g2;
		end
		if (meas_take) pix_q <= head.gray;
	end

	assign div_start = (state_q == S_DIV_ST) && (gsum_q != '0);

	gwb_div #(.WW(WW), .GW(GW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wsum_q),
		.divisor  (gsum_q),
		.rsp      (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			nw0_q   <= '0;
			nw1_q   <= '0;
			nw2_q   <= '0;
			wsum_q  <= '0;
			gsum_q  <= '0;
			thr_q   <= '0;
			flat_q  <= 1'b0;
			done_s1 <= 1'b0;
		end else if (restart) begin
			state_q <= S_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			nw0_q   <= '0;
			nw1_q   <= '0;
			nw2_q   <= '0;
			wsum_q  <= '0;
			gsum_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (meas_take) begin
						x_q <= xs;
						y_q <= ys;
						if (oob) begin
							nw0_q  <= '0;
							nw1_q  <= '0;
							nw2_q  <= '0;
							wsum_q <= '0;
							gsum_q <= '0;
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (en0) nw0_q <= c0;
					nw2_q   <= nw1_q;
					nw1_q   <= pix_q;
					done_s1 <= 1'b0;
					if (xlast) begin
						x_q <= '0;
						if (lastrow) begin
							y_q     <= '0;
							done_s1 <= 1'b1;
						end else begin
							y_q <= y_q + YW'(1);
						end
					end else begin
						x_q <= x_q + XW'(1);
					end
					state_q <= S_ACC;
				end
				S_ACC: begin
					wsum_q <= wsum_q + WW'(p0) + WW'(p1) + WW'(p2);
					gsum_q <= gsum_q + GW'(g0_s1) + GW'(g1_s1) + GW'(g2_s1);
					state_q <= done_s1 ? S_DIV_ST : S_IDLE;
				end
				S_DIV_ST: begin
					nw0_q  <= '0;
					nw1_q  <= '0;
					nw2_q  <= '0;
					wsum_q <= '0;
					gsum_q <= '0;
					if (gsum_q == '0) begin
						thr_q   <= '0;
						flat_q  <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV_WT;
					end
				end
				S_DIV_WT: begin
					if (drsp.done) begin
						thr_q   <= drsp.quo;
						flat_q  <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bin_take) begin
			out_kind <= KIND_PIXEL;
			out_bit  <= (head.gray >= thr_q);
			out_thr  <= thr_q;
			out_flat <= flat_q;
		end else if (out_wr_thr) begin
			out_kind <= KIND_THRESH;
			out_bit  <= 1'b0;
			out_thr  <= thr_q;
			out_flat <= flat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (bin_take || out_wr_thr) begin
			out_v <= 1'b1;
		end else if (out_pop) begin
			out_v <= 1'b0;
		end
	end
endmodule

/* sv/gradient_weighted_binarizer.sv */
// Top level of the gradient weighted binarizer: configuration port and core.
//
// Pixels are pushed twice per frame in raster order: a measuring pass (action 0)
// accumulates gray*G and G, where G is the larger absolute central difference,
// and its last pixel yields a threshold result; a binarizing pass (action 1)
// returns one bit per pixel, gray >= threshold. A two-entry input queue feeds a
// sequencer. A binarizing pixel goes straight into the result register once
// that register is free. A measuring pixel passes through the registered read
// of the two line buffers, then the forming of the gradients, then the adding
// of the products into the sums. The last pixel of a frame adds a restoring
// division of one quotient bit per cycle. Writing a size register restarts the
// measuring pass; the threshold in force is kept.
module gradient_weighted_binarizer import gwb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             action,
	input  logic [PIX_W-1:0] gray,
	output logic             empty,
	input  logic             pop,
	output logic             result_kind,
	output logic             pixel_bit,
	output logic [PIX_W-1:0] threshold,
	output logic             flat_image,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	`include "gradient_weighted_binarizer_assert.svh"

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);

	logic [CFG_W-1:0] width_q, height_q;
	logic             cfg_wr;
	logic [XW:0]      w_eff;
	logic [YW:0]      h_eff;
	item_t            in_item, head;
	logic             head_v, head_pop, out_v;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WIDTH) width_q <= pwdata[CFG_W-1:0];
			else height_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_WIDTH) ? 32'(width_q) : 32'(height_q);

	always_comb begin
		if (width_q == '0) w_eff = (XW+1)'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = (XW+1)'(MAX_WIDTH);
		else w_eff = (XW+1)'(width_q);
		if (height_q == '0) h_eff = (YW+1)'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT)) h_eff = (YW+1)'(MAX_HEIGHT);
		else h_eff = (YW+1)'(height_q);
	end

	assign in_item.action = action;
	assign in_item.gray   = gray;

	gwb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_item),
		.full     (full),
		.head_v   (head_v),
		.head     (head),
		.head_pop (head_pop)
	);

	gwb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wr),
		.w        (w_eff),
		.h        (h_eff),
		.head_v   (head_v),
		.head     (head),
		.head_pop (head_pop),
		.out_v    (out_v),
		.out_pop  (pop),
		.out_kind (result_kind),
		.out_bit  (pixel_bit),
		.out_thr  (threshold),
		.out_flat (flat_image)
	);

	assign empty = !out_v;

	`GWB_ASSERT_IMP(a_flat_zero, !empty && flat_image, threshold == '0)
	`GWB_ASSERT_IMP(a_thr_no_bit, !empty && (result_kind == KIND_THRESH), !pixel_bit)
	`GWB_ASSERT_NXT(a_result_held, !empty && !pop, !empty)
endmodule
